@@ hdl/switch_debounce_command_decoder_defines.svh @@
// assertion macros used by the rtl file switch_debounce_command_decoder.sv
`ifndef SWITCH_DEBOUNCE_COMMAND_DECODER_DEFINES_SVH
`define SWITCH_DEBOUNCE_COMMAND_DECODER_DEFINES_SVH

// same-cycle implication, checked on the rising edge of clk_i outside reset
`define SDC_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked on the rising edge of clk_i outside reset
`define SDC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/sdc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sdc_pkg;

  // sample and level widths
  localparam int SAMPLE_BITS = 16;
  localparam int LEVEL_BITS  = 8;
  localparam int CMD_BITS    = 4;

  // configuration port
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  // step switches sit in the high byte of the sample
  localparam int STEP_SHIFT  = 8;
  localparam int STEP_BITS   = 4;
  localparam int SW_LED_INC  = 0;
  localparam int SW_LED_DEC  = 1;
  localparam int SW_FAN_INC  = 2;
  localparam int SW_FAN_DEC  = 3;

  // register reset values
  localparam logic [LEVEL_BITS-1:0] LEVEL_MIN_RESET = '0;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX_RESET = '1;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_LED_MIN = 2'd0,
    REG_LED_MAX = 2'd1,
    REG_FAN_MIN = 2'd2,
    REG_FAN_MAX = 2'd3
  } sdc_reg_e;

  typedef logic [LEVEL_BITS-1:0] level_t;

  // result of one level update: new level and moved flag
  typedef struct packed {
    logic   moved;
    level_t level;
  } step_t;

endpackage

`default_nettype wire

@@ hdl/switch_debounce_command_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Switch debouncer with command decoder and LED / fan level stepper. Each
// accepted request is one raw scan sample; a stable bit flips only when this
// sample and the one before agree and both differ from it. One request is
// taken every clock cycle while in_stall_o is low, and it passes through an
// input register, then the debounce and level-step logic, then a result
// register; the debounce and level state advance as a request moves into the
// result register. A stall on the result side holds the input side once the
// input register is also full. The four level limits are written through the
// APB port at byte addresses 0, 4, 8 and 12 (led min, led max, fan min, fan max)
// and read back there; pready is always high.
module switch_debounce_command_decoder (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // sample channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [sdc_pkg::SAMPLE_BITS-1:0]     raw_sample_i,
  // result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [sdc_pkg::SAMPLE_BITS-1:0]          stable_inputs_o,
  output logic [sdc_pkg::SAMPLE_BITS-1:0]          changed_mask_o,
  output logic [sdc_pkg::CMD_BITS-1:0]             command_levels_o,
  output logic [sdc_pkg::CMD_BITS-1:0]             command_strobes_o,
  output logic [sdc_pkg::LEVEL_BITS-1:0]           led_level_o,
  output logic                                     led_level_moved_o,
  output logic [sdc_pkg::LEVEL_BITS-1:0]           fan_level_o,
  output logic                                     fan_level_moved_o,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [sdc_pkg::ADDR_BITS-1:0]       paddr,
  input  wire logic [sdc_pkg::DATA_BITS-1:0]       pwdata,
  output logic [sdc_pkg::DATA_BITS-1:0]            prdata,
  output logic                                     pready
);

  import sdc_pkg::*;

`include "switch_debounce_command_decoder_defines.svh"

  // step up by one, saturating at hi
  function automatic step_t step_up(level_t lvl, level_t hi);
    logic [LEVEL_BITS:0] nxt;
    step_t               res;
    nxt = {1'b0, lvl} + {{LEVEL_BITS{1'b0}}, 1'b1};
    if (nxt > {1'b0, hi}) begin
      res.level = hi;
      res.moved = 1'b0;
    end else begin
      res.level = nxt[LEVEL_BITS-1:0];
      res.moved = 1'b1;
    end
    return res;
  endfunction

  // step down by one, saturating at lo; zero counts as below lo
  function automatic step_t step_down(level_t lvl, level_t lo);
    level_t dec;
    step_t  res;
    dec = lvl - {{(LEVEL_BITS-1){1'b0}}, 1'b1};
    if (lvl == '0 || dec < lo) begin
      res.level = lo;
      res.moved = 1'b0;
    end else begin
      res.level = dec;
      res.moved = 1'b1;
    end
    return res;
  endfunction

  // configuration registers
  level_t led_min_q, led_max_q, fan_min_q, fan_max_q;
  logic   cfg_wr;
  sdc_reg_e cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = sdc_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_min_q <= LEVEL_MIN_RESET;
      led_max_q <= LEVEL_MAX_RESET;
      fan_min_q <= LEVEL_MIN_RESET;
      fan_max_q <= LEVEL_MAX_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_LED_MIN: led_min_q <= pwdata[LEVEL_BITS-1:0];
        REG_LED_MAX: led_max_q <= pwdata[LEVEL_BITS-1:0];
        REG_FAN_MIN: fan_min_q <= pwdata[LEVEL_BITS-1:0];
        REG_FAN_MAX: fan_max_q <= pwdata[LEVEL_BITS-1:0];
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_sel)
      REG_LED_MIN: prdata = {{(DATA_BITS-LEVEL_BITS){1'b0}}, led_min_q};
      REG_LED_MAX: prdata = {{(DATA_BITS-LEVEL_BITS){1'b0}}, led_max_q};
      REG_FAN_MIN: prdata = {{(DATA_BITS-LEVEL_BITS){1'b0}}, fan_min_q};
      REG_FAN_MAX: prdata = {{(DATA_BITS-LEVEL_BITS){1'b0}}, fan_max_q};
    endcase
  end

  // pipeline handshake
  logic                   in_valid_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   out_valid_q;
  logic                   advance;
  logic                   in_take;

  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign in_take    = in_valid_i & ~in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= raw_sample_i;
    end
  end

  // debounce and level state
  logic [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic [SAMPLE_BITS-1:0] stable_q, stable_d;
  level_t                 led_q, led_d;
  level_t                 fan_q, fan_d;
  logic [SAMPLE_BITS-1:0] changed;
  logic [STEP_BITS-1:0]   rise;
  step_t                  led_inc, led_dec, fan_inc, fan_dec;
  logic                   led_moved, fan_moved;

  // two-sample agreement and level stepping, inc before dec
  always_comb begin
    changed  = ~(prev_q ^ sample_q) & (sample_q ^ stable_q);
    stable_d = stable_q ^ changed;
    prev_d   = sample_q;
    rise     = changed[STEP_SHIFT +: STEP_BITS] & stable_d[STEP_SHIFT +: STEP_BITS];

    led_inc = rise[SW_LED_INC] ? step_up(led_q, led_max_q) : step_t'{1'b0, led_q};
    led_dec = rise[SW_LED_DEC] ? step_down(led_inc.level, led_min_q) : led_inc;
    fan_inc = rise[SW_FAN_INC] ? step_up(fan_q, fan_max_q) : step_t'{1'b0, fan_q};
    fan_dec = rise[SW_FAN_DEC] ? step_down(fan_inc.level, fan_min_q) : fan_inc;

    led_d     = led_dec.level;
    led_moved = led_dec.moved;
    fan_d     = fan_dec.level;
    fan_moved = fan_dec.moved;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      stable_q <= '0;
      led_q    <= '0;
      fan_q    <= '0;
    end else if (advance) begin
      prev_q   <= prev_d;
      stable_q <= stable_d;
      led_q    <= led_d;
      fan_q    <= fan_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      stable_inputs_o   <= stable_d;
      changed_mask_o    <= changed;
      command_levels_o  <= stable_d[CMD_BITS-1:0];
      command_strobes_o <= changed[CMD_BITS-1:0];
      led_level_o       <= led_d;
      led_level_moved_o <= led_moved;
      fan_level_o       <= fan_d;
      fan_level_moved_o <= fan_moved;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  `SDC_ASSERT_NEXT(a_stable_needs_agreement, advance,
    ((stable_q ^ $past(stable_q)) & ($past(prev_q) ^ $past(sample_q))) == '0,
    "stable bit flipped without two agreeing samples")

  `SDC_ASSERT_NEXT(a_state_holds_when_idle, !advance,
    $stable(stable_q) && $stable(prev_q) && $stable(led_q) && $stable(fan_q),
    "debounce state moved without a request")

  `SDC_ASSERT_NOW(a_led_move_needs_edge, out_valid_q && led_level_moved_o,
    changed_mask_o[STEP_SHIFT + SW_LED_INC] || changed_mask_o[STEP_SHIFT + SW_LED_DEC],
    "led level moved without a step switch change")

  `SDC_ASSERT_NOW(a_fan_move_needs_edge, out_valid_q && fan_level_moved_o,
    changed_mask_o[STEP_SHIFT + SW_FAN_INC] || changed_mask_o[STEP_SHIFT + SW_FAN_DEC],
    "fan level moved without a step switch change")

  `SDC_ASSERT_NOW(a_result_tracks_state, out_valid_q,
    stable_inputs_o == stable_q && led_level_o == led_q && fan_level_o == fan_q,
    "result register out of step with debounce state")

endmodule

`default_nettype wire
